>>> sv/mqsa_pkg.sv
// Shared types, codes and defaults for the multi-queue shared-array block.
package mqsa_pkg;

    localparam int TOTAL_SLOTS_DEF = 32;
    localparam int MAX_QUEUES_DEF  = 8;

    localparam int OP_W          = 1;
    localparam int QUEUE_INDEX_W = 3;
    localparam int QUEUE_COUNT_W = 4;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [QUEUE_INDEX_W-1:0] queue_index;
        logic signed [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
    } rsp_t;

    // control part of one command from the front end to the back end
    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [STATUS_W-1:0] status;
    } cmd_ctl_t;

endpackage

>>> sv/multi_queue_shared_array.sv
// Top level: several linear queues sharing one slot RAM behind queue-style ports.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  request   | push / full             | req_t: operation, queue_index, value
//  result    | empty / pop             | rsp_t: status, read_value
//  config    | queue_count_we          | queue_count (live queue count)
//
// Each transaction passes the front end (count check and update, stored with
// the command in the command queue) and then the back end (slot RAM access,
// registered read); the result is held in the result register until popped,
// and one transaction per cycle is sustained while the consumer pops each
// result, set by the single slot RAM port used per command.
// Reset clears all counts and sets the queue count to one; the slot RAM is
// not cleared, since only slots written after a count clear are ever read.
// A stalled consumer holds the result; the two-entry command queue lets the
// front end keep accepting until it fills, then full is raised.
module multi_queue_shared_array #(
    parameter int TOTAL_SLOTS = mqsa_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_QUEUES  = mqsa_pkg::MAX_QUEUES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               queue_count_we,
    input  logic [mqsa_pkg::QUEUE_COUNT_W-1:0] queue_count,
    input  logic                               push,
    output logic                               full,
    input  mqsa_pkg::req_t                     request,
    output logic                               empty,
    input  logic                               pop,
    output mqsa_pkg::rsp_t                     result
);

    localparam int AW = $clog2(TOTAL_SLOTS);
    localparam int VW = mqsa_pkg::VALUE_W;
    localparam int CTL_W = $bits(mqsa_pkg::cmd_ctl_t);
    localparam int CMD_W = CTL_W + AW + VW;

    logic                     accept;
    mqsa_pkg::cmd_ctl_t       front_ctl;
    logic [AW-1:0]            front_addr;
    logic [CMD_W-1:0]         fifo_in;
    logic [CMD_W-1:0]         fifo_out;
    logic                     fifo_empty;
    logic                     fifo_pop;
    mqsa_pkg::cmd_ctl_t       back_ctl;
    logic [AW-1:0]            back_addr;
    logic [VW-1:0]            back_value;

    // take a request whenever the command queue has room
    assign accept = push && !full;

    mqsa_front #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .MAX_QUEUES  (MAX_QUEUES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (queue_count_we),
        .cfg_data (queue_count),
        .accept   (accept),
        .req      (request),
        .cmd_ctl  (front_ctl),
        .cmd_addr (front_addr)
    );

    // pack control, slot address and value into one queue entry
    assign fifo_in = {front_ctl, front_addr, request.write_value};

    mqsa_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (fifo_in),
        .full      (full),
        .pop       (fifo_pop),
        .pop_data  (fifo_out),
        .empty     (fifo_empty)
    );

    assign {back_ctl, back_addr, back_value} = fifo_out;

    mqsa_back #(
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (fifo_empty),
        .cmd_pop   (fifo_pop),
        .cmd_ctl   (back_ctl),
        .cmd_addr  (back_addr),
        .cmd_value (back_value),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> sv/mqsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mqsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mqsa_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module mqsa_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("command queue both full and empty");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("command queue count did not drop on pop");

endmodule

>>> sv/mqsa_front.sv
// Front end: checks each request against the counts, updates them, forms a slot command.
module mqsa_front #(
    parameter int TOTAL_SLOTS = mqsa_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_QUEUES  = mqsa_pkg::MAX_QUEUES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mqsa_pkg::QUEUE_COUNT_W-1:0]   cfg_data,
    input  logic                                 accept,
    input  mqsa_pkg::req_t                       req,
    output mqsa_pkg::cmd_ctl_t                   cmd_ctl,
    output logic [$clog2(TOTAL_SLOTS)-1:0]       cmd_addr
);

    localparam int AW     = $clog2(TOTAL_SLOTS);
    localparam int CW     = $clog2(TOTAL_SLOTS + 1);
    localparam int QDEPTH = (MAX_QUEUES < 8) ? MAX_QUEUES : 8;
    localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NMAX   = (MAX_QUEUES < 15) ? MAX_QUEUES : 15;
    localparam int QW     = mqsa_pkg::QUEUE_INDEX_W;
    localparam int NW     = mqsa_pkg::QUEUE_COUNT_W;
    localparam int BW     = CW + QW;

    // partition size for each live queue count 1..15
    localparam logic [CW-1:0] SIZE_TAB [15] = '{
        CW'(TOTAL_SLOTS / 1),  CW'(TOTAL_SLOTS / 2),  CW'(TOTAL_SLOTS / 3),
        CW'(TOTAL_SLOTS / 4),  CW'(TOTAL_SLOTS / 5),  CW'(TOTAL_SLOTS / 6),
        CW'(TOTAL_SLOTS / 7),  CW'(TOTAL_SLOTS / 8),  CW'(TOTAL_SLOTS / 9),
        CW'(TOTAL_SLOTS / 10), CW'(TOTAL_SLOTS / 11), CW'(TOTAL_SLOTS / 12),
        CW'(TOTAL_SLOTS / 13), CW'(TOTAL_SLOTS / 14), CW'(TOTAL_SLOTS / 15)
    };

    logic [NW-1:0]     live_reg;
    logic [NW-1:0]     live_next;
    logic [CW-1:0]     size_reg;
    logic [CW-1:0]     size_next;
    logic [CW-1:0]     ins_cnt_reg [QDEPTH];
    logic [CW-1:0]     rem_cnt_reg [QDEPTH];
    logic [QIDX_W-1:0] qi;
    logic              in_range;
    logic [CW-1:0]     ins_cnt;
    logic [CW-1:0]     rem_cnt;
    logic [CW-1:0]     cnt_sel;
    logic [BW-1:0]     base;
    logic [BW-1:0]     slot;

    // saturate the written count into 1..NMAX
    always_comb
    begin
        live_next = cfg_data;
        if (cfg_data == '0)
        begin
            live_next = NW'(1);
        end
        else if (cfg_data > NW'(NMAX))
        begin
            live_next = NW'(NMAX);
        end
        size_next = SIZE_TAB[live_next - NW'(1)];
    end

    assign in_range = ({1'b0, req.queue_index} < live_reg);
    assign qi       = QIDX_W'(req.queue_index);
    assign ins_cnt  = in_range ? ins_cnt_reg[qi] : '0;
    assign rem_cnt  = in_range ? rem_cnt_reg[qi] : '0;

    always_comb
    begin
        cmd_ctl.wr     = 1'b0;
        cmd_ctl.rd     = 1'b0;
        cmd_ctl.status = mqsa_pkg::ST_DONE;
        if (!in_range)
        begin
            cmd_ctl.status = mqsa_pkg::ST_BAD_INDEX;
        end
        else if (req.operation == mqsa_pkg::OP_INSERT)
        begin
            if (ins_cnt >= size_reg)
            begin
                cmd_ctl.status = mqsa_pkg::ST_FULL;
            end
            else
            begin
                cmd_ctl.wr = 1'b1;
            end
        end
        else
        begin
            if (rem_cnt >= ins_cnt)
            begin
                cmd_ctl.status = mqsa_pkg::ST_EMPTY;
            end
            else
            begin
                cmd_ctl.rd = 1'b1;
            end
        end
    end

    // slot = queue * partition size + insert or remove position
    assign cnt_sel  = cmd_ctl.rd ? rem_cnt : ins_cnt;
    assign base     = BW'(req.queue_index * size_reg);
    assign slot     = base + BW'(cnt_sel);
    assign cmd_addr = slot[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= NW'(1);
            size_reg <= CW'(TOTAL_SLOTS);
            for (int i = 0; i < QDEPTH; i++)
            begin
                ins_cnt_reg[i] <= '0;
                rem_cnt_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            live_reg <= live_next;
            size_reg <= size_next;
            for (int i = 0; i < QDEPTH; i++)
            begin
                ins_cnt_reg[i] <= '0;
                rem_cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (cmd_ctl.wr)
            begin
                ins_cnt_reg[qi] <= ins_cnt + CW'(1);
            end
            if (cmd_ctl.rd)
            begin
                rem_cnt_reg[qi] <= rem_cnt + CW'(1);
            end
        end
    end

    a_rem_le_ins: assert property (@(posedge clk) disable iff (!rst_n)
        in_range |-> (rem_cnt <= ins_cnt))
        else $error("remove count passed insert count");

    a_ins_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && cmd_ctl.wr |=>
            ins_cnt_reg[$past(qi)] == CW'($past(ins_cnt) + CW'(1)))
        else $error("insert count did not advance");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (ins_cnt_reg[0] == '0) && (rem_cnt_reg[0] == '0))
        else $error("counts not cleared by queue count write");

endmodule

>>> sv/mqsa_back.sv
// Back end: carries out slot writes and reads and holds the result for the consumer.
module mqsa_back #(
    parameter int TOTAL_SLOTS = mqsa_pkg::TOTAL_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_empty,
    output logic                           cmd_pop,
    input  mqsa_pkg::cmd_ctl_t             cmd_ctl,
    input  logic [$clog2(TOTAL_SLOTS)-1:0] cmd_addr,
    input  logic [mqsa_pkg::VALUE_W-1:0]   cmd_value,
    output logic                           empty,
    input  logic                           pop,
    output mqsa_pkg::rsp_t                 result
);

    localparam int VW = mqsa_pkg::VALUE_W;

    logic                         issue;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_rd_reg;
    logic [mqsa_pkg::STATUS_W-1:0] out_status_reg;
    logic [VW-1:0]                rdata;

    // issue when the result register is free or being drained
    assign issue          = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_pop        = issue;
    assign out_valid_next = issue || (out_valid_reg && !pop);

    mqsa_ram #(
        .WIDTH (VW),
        .DEPTH (TOTAL_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (issue && cmd_ctl.wr),
        .waddr (cmd_addr),
        .wdata (cmd_value),
        .re    (issue && cmd_ctl.rd),
        .raddr (cmd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_rd_reg     <= cmd_ctl.rd;
            out_status_reg <= cmd_ctl.status;
        end
    end

    assign empty             = !out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.read_value = out_rd_reg ? rdata : '0;

    a_issue_fills: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> out_valid_reg)
        else $error("issued command produced no result");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rd_reg |-> out_status_reg == mqsa_pkg::ST_DONE)
        else $error("slot read without done status");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !(cmd_ctl.wr && cmd_ctl.rd))
        else $error("command both writes and reads a slot");

endmodule
